// ===== hdl/quaternion_multiply_normalize_macros.svh =====
// Assertion macros for the quaternion multiply-normalize RTL.
`ifndef QUATERNION_MULTIPLY_NORMALIZE_MACROS_SVH
`define QUATERNION_MULTIPLY_NORMALIZE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define QMN_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define QMN_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/qmn_pkg.sv =====
// Shared types and constants for the quaternion multiply-normalize block.
package qmn_pkg;

    localparam int COMP_W      = 16;
    localparam int PROD_W      = 32;
    localparam int R_W         = 34;
    localparam int MAG_W       = 33;
    localparam int SUM_W       = 66;
    localparam int ROOT_W      = 33;
    localparam int REM_W       = 36;
    localparam int SQRT_STEPS  = 33;
    localparam int LANES       = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][MAG_W-1:0] mag;
        logic [SUM_W-1:0]            sum;
    } item_t;

endpackage

// ===== hdl/qmn_front.sv =====
// Front end: Hamilton product, component magnitudes and the exact sum of squares.
module qmn_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   a_x,
    input  logic signed [15:0]   a_y,
    input  logic signed [15:0]   a_z,
    input  logic signed [15:0]   a_w,
    input  logic signed [15:0]   b_x,
    input  logic signed [15:0]   b_y,
    input  logic signed [15:0]   b_z,
    input  logic signed [15:0]   b_w,
    output logic                 out_valid,
    input  logic                 out_ready,
    output qmn_pkg::item_t       out_item
);

    logic                                    en;
    logic [5:0]                              v_reg;
    logic signed [qmn_pkg::PROD_W-1:0]       prod [16];
    logic signed [qmn_pkg::PROD_W-1:0]       p_reg [16];
    logic signed [qmn_pkg::R_W-1:0]          r_reg [4];
    logic [3:0]                              neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [qmn_pkg::MAG_W-1:0]               mag3_reg [4];
    logic [qmn_pkg::MAG_W-1:0]               mag4_reg [4];
    logic [qmn_pkg::MAG_W-1:0]               mag5_reg [4];
    logic [qmn_pkg::MAG_W-1:0]               mag6_reg [4];
    logic [qmn_pkg::SUM_W-1:0]               sq_reg [4];
    logic [qmn_pkg::SUM_W-1:0]               pair_reg [2];
    logic [qmn_pkg::SUM_W-1:0]               sum_reg;
    logic signed [qmn_pkg::R_W-1:0]          r_abs [4];

    assign en       = !v_reg[5] || out_ready;
    assign in_ready = en;

    assign prod[0]  = b_w * a_x;
    assign prod[1]  = b_x * a_w;
    assign prod[2]  = b_y * a_z;
    assign prod[3]  = b_z * a_y;
    assign prod[4]  = b_w * a_y;
    assign prod[5]  = b_y * a_w;
    assign prod[6]  = b_z * a_x;
    assign prod[7]  = b_x * a_z;
    assign prod[8]  = b_w * a_z;
    assign prod[9]  = b_z * a_w;
    assign prod[10] = b_x * a_y;
    assign prod[11] = b_y * a_x;
    assign prod[12] = b_w * a_w;
    assign prod[13] = b_x * a_x;
    assign prod[14] = b_y * a_y;
    assign prod[15] = b_z * a_z;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            r_abs[i] = r_reg[i][qmn_pkg::R_W-1] ? -r_reg[i] : r_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 16; i++)
            begin
                p_reg[i] <= prod[i];
            end
            r_reg[0] <= qmn_pkg::R_W'(p_reg[0]) + qmn_pkg::R_W'(p_reg[1])
                      + qmn_pkg::R_W'(p_reg[2]) - qmn_pkg::R_W'(p_reg[3]);
            r_reg[1] <= qmn_pkg::R_W'(p_reg[4]) + qmn_pkg::R_W'(p_reg[5])
                      + qmn_pkg::R_W'(p_reg[6]) - qmn_pkg::R_W'(p_reg[7]);
            r_reg[2] <= qmn_pkg::R_W'(p_reg[8]) + qmn_pkg::R_W'(p_reg[9])
                      + qmn_pkg::R_W'(p_reg[10]) - qmn_pkg::R_W'(p_reg[11]);
            r_reg[3] <= qmn_pkg::R_W'(p_reg[12]) - qmn_pkg::R_W'(p_reg[13])
                      - qmn_pkg::R_W'(p_reg[14]) - qmn_pkg::R_W'(p_reg[15]);
            for (int i = 0; i < 4; i++)
            begin
                neg3_reg[i] <= r_reg[i][qmn_pkg::R_W-1];
                mag3_reg[i] <= r_abs[i][qmn_pkg::MAG_W-1:0];
                sq_reg[i]   <= qmn_pkg::SUM_W'(mag3_reg[i]) * qmn_pkg::SUM_W'(mag3_reg[i]);
                mag4_reg[i] <= mag3_reg[i];
                mag5_reg[i] <= mag4_reg[i];
                mag6_reg[i] <= mag5_reg[i];
            end
            neg4_reg    <= neg3_reg;
            neg5_reg    <= neg4_reg;
            neg6_reg    <= neg5_reg;
            pair_reg[0] <= sq_reg[0] + sq_reg[1];
            pair_reg[1] <= sq_reg[2] + sq_reg[3];
            sum_reg     <= pair_reg[0] + pair_reg[1];
        end
    end

    always_comb
    begin
        out_item.neg = neg6_reg;
        out_item.sum = sum_reg;
        for (int i = 0; i < 4; i++)
        begin
            out_item.mag[i] = mag6_reg[i];
        end
    end

    assign out_valid = v_reg[5];

endmodule

// ===== hdl/qmn_fifo.sv =====
// Short queue that decouples the front end from the back end.
module qmn_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  qmn_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output qmn_pkg::item_t  out_item
);

    qmn_pkg::item_t                       entry_reg [qmn_pkg::QUEUE_DEPTH];
    logic [qmn_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [qmn_pkg::QUEUE_CNT_W-1:0]      count_reg, count_next;
    logic                                 push, pop;

    assign in_ready  = count_reg != qmn_pkg::QUEUE_CNT_W'(qmn_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hdl/qmn_back.sv =====
// Back end: pipelined integer square root, per-lane division, clamp and output register.
`include "quaternion_multiply_normalize_macros.svh"
module qmn_back #(
    parameter int FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  qmn_pkg::item_t      in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  r_x,
    output logic signed [15:0]  r_y,
    output logic signed [15:0]  r_z,
    output logic signed [15:0]  r_w,
    output logic                degenerate
);

    localparam int QW    = FRAC_BITS + 1;
    localparam int DW    = qmn_pkg::MAG_W + FRAC_BITS + 1;
    localparam int NS    = qmn_pkg::SQRT_STEPS;
    localparam int NDIV  = FRAC_BITS + 1;
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    logic en;

    // Square root stages.
    logic                          sq_v_reg    [0:NS];
    qmn_pkg::item_t                sq_item_reg [0:NS];
    logic [qmn_pkg::REM_W-1:0]     sq_rem_reg  [0:NS];
    logic [qmn_pkg::ROOT_W-1:0]    sq_root_reg [0:NS];
    logic [qmn_pkg::REM_W-1:0]     sq_rem_next [0:NS-1];
    logic [qmn_pkg::ROOT_W-1:0]    sq_root_next[0:NS-1];

    // Division stages.
    logic                          dv_v_reg    [0:NDIV];
    logic                          dv_zero_reg [0:NDIV];
    logic [3:0]                    dv_neg_reg  [0:NDIV];
    logic [qmn_pkg::ROOT_W-1:0]    dv_n_reg    [0:NDIV];
    logic [qmn_pkg::ROOT_W-1:0]    dv_rem_reg  [0:NDIV][4];
    logic [QW-1:0]                 dv_low_reg  [0:NDIV][4];
    logic [QW-1:0]                 dv_q_reg    [0:NDIV][4];
    logic [qmn_pkg::ROOT_W-1:0]    dv_rem_next [0:NDIV-1][4];
    logic [QW-1:0]                 dv_q_next   [0:NDIV-1][4];
    logic [DW-1:0]                 dvd         [4];

    // Output stage.
    logic                          out_v_reg;
    logic                          deg_reg;
    logic [15:0]                   res_reg  [4];
    logic [15:0]                   res_next [4];

    assign en       = !out_v_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        logic [qmn_pkg::REM_W-1:0] rs;
        logic [qmn_pkg::REM_W-1:0] trial;
        for (int k = 0; k < NS; k++)
        begin
            rs    = {sq_rem_reg[k][qmn_pkg::REM_W-3:0],
                     sq_item_reg[k].sum[2*(NS-1-k)+1 -: 2]};
            trial = qmn_pkg::REM_W'({sq_root_reg[k], 2'b01});
            if (rs >= trial)
            begin
                sq_rem_next[k]  = rs - trial;
                sq_root_next[k] = {sq_root_reg[k][qmn_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = rs;
                sq_root_next[k] = {sq_root_reg[k][qmn_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            dvd[i] = (DW'(sq_item_reg[NS].mag[i]) << FRAC_BITS)
                   + DW'(sq_root_reg[NS] >> 1);
        end
    end

    always_comb
    begin
        logic [qmn_pkg::ROOT_W:0] rs;
        for (int k = 0; k < NDIV; k++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rs = {dv_rem_reg[k][i], dv_low_reg[k][i][FRAC_BITS-k]};
                if (rs >= {1'b0, dv_n_reg[k]})
                begin
                    dv_rem_next[k][i] = qmn_pkg::ROOT_W'(rs - {1'b0, dv_n_reg[k]});
                    dv_q_next[k][i]   = {dv_q_reg[k][i][QW-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_next[k][i] = rs[qmn_pkg::ROOT_W-1:0];
                    dv_q_next[k][i]   = {dv_q_reg[k][i][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Clamp to one, apply the sign and saturate to the 16-bit field; a zero norm gives zero.
    always_comb
    begin
        logic [31:0] q;
        for (int i = 0; i < 4; i++)
        begin
            q = 32'(dv_q_reg[NDIV][i]);
            if (q > ONE)
            begin
                q = ONE;
            end
            if (dv_zero_reg[NDIV])
            begin
                res_next[i] = '0;
            end
            else if (dv_neg_reg[NDIV][i])
            begin
                res_next[i] = (q > 32'd32768) ? 16'h8000 : 16'(32'd0 - q);
            end
            else
            begin
                res_next[i] = (q > 32'd32767) ? 16'h7fff : q[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= NDIV; k++)
            begin
                dv_v_reg[k] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_v_reg[0] <= in_valid;
            for (int k = 0; k < NS; k++)
            begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
            dv_v_reg[0] <= sq_v_reg[NS];
            for (int k = 0; k < NDIV; k++)
            begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
            out_v_reg <= dv_v_reg[NDIV];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_item_reg[0] <= in_item;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 0; k < NS; k++)
            begin
                sq_item_reg[k+1] <= sq_item_reg[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
            end

            dv_zero_reg[0] <= sq_root_reg[NS] == '0;
            dv_neg_reg[0]  <= sq_item_reg[NS].neg;
            dv_n_reg[0]    <= sq_root_reg[NS];
            for (int i = 0; i < 4; i++)
            begin
                dv_rem_reg[0][i] <= dvd[i][DW-1:QW];
                dv_low_reg[0][i] <= dvd[i][QW-1:0];
                dv_q_reg[0][i]   <= '0;
            end
            for (int k = 0; k < NDIV; k++)
            begin
                dv_zero_reg[k+1] <= dv_zero_reg[k];
                dv_neg_reg[k+1]  <= dv_neg_reg[k];
                dv_n_reg[k+1]    <= dv_n_reg[k];
                for (int i = 0; i < 4; i++)
                begin
                    dv_rem_reg[k+1][i] <= dv_rem_next[k][i];
                    dv_low_reg[k+1][i] <= dv_low_reg[k][i];
                    dv_q_reg[k+1][i]   <= dv_q_next[k][i];
                end
            end

            deg_reg <= dv_zero_reg[NDIV];
            for (int i = 0; i < 4; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign out_valid  = out_v_reg;
    assign degenerate = deg_reg;
    assign r_x        = res_reg[0];
    assign r_y        = res_reg[1];
    assign r_z        = res_reg[2];
    assign r_w        = res_reg[3];

    `QMN_CHECK(a_root_floor, sq_v_reg[NS], (68'(sq_root_reg[NS]) * 68'(sq_root_reg[NS]) <= 68'(sq_item_reg[NS].sum)) && ((68'(sq_root_reg[NS]) + 68'd1) * (68'(sq_root_reg[NS]) + 68'd1) > 68'(sq_item_reg[NS].sum)), "square root stage gave a root that is not the floor of the root")
    `QMN_CHECK(a_degenerate_zero, out_v_reg && deg_reg, (r_x == '0) && (r_y == '0) && (r_z == '0) && (r_w == '0), "degenerate result carries nonzero components")
    `QMN_CHECK(a_normal_nonzero, out_v_reg && !deg_reg, (r_x != '0) || (r_y != '0) || (r_z != '0) || (r_w != '0), "normalized result has all components zero")

endmodule

// ===== hdl/quaternion_multiply_normalize.sv =====
// Throughput: one item per cycle unless stalled as described below; the 33-stage square root
// and FRAC_BITS + 1 divide stages are fully pipelined, and a four-entry queue decouples the
// product and the normalize halves. The front end stalls only when that queue is full;
// the back end stalls only on out_ready.
// Reset: rst_n is asynchronous and active low; it clears all valid bits and queue pointers.
// No state is kept between items, so no clearing pass is needed after reset.
module quaternion_multiply_normalize #(
    parameter int FRAC_BITS = 14
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  a_x,
    input  logic signed [15:0]  a_y,
    input  logic signed [15:0]  a_z,
    input  logic signed [15:0]  a_w,
    input  logic signed [15:0]  b_x,
    input  logic signed [15:0]  b_y,
    input  logic signed [15:0]  b_z,
    input  logic signed [15:0]  b_w,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  r_x,
    output logic signed [15:0]  r_y,
    output logic signed [15:0]  r_z,
    output logic signed [15:0]  r_w,
    output logic                degenerate
);

    // The front end forms the exact Hamilton product B * A, the component magnitudes
    // and signs, and the exact sum of squares. Each transfer out of it is one queue entry.
    logic            front_valid;
    logic            front_ready;
    qmn_pkg::item_t  front_item;

    // The back end pulls entries from the queue whenever its output register can move.
    logic            back_valid;
    logic            back_ready;
    qmn_pkg::item_t  back_item;

    qmn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .a_w       (a_w),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .b_w       (b_w),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_item  (front_item)
    );

    // The queue lets the front end keep accepting while the output side is stalled.
    qmn_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    // The back end computes the integer norm, divides each magnitude by it with
    // rounding to nearest, clamps to one and flags a zero norm as degenerate.
    qmn_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (back_valid),
        .in_ready   (back_ready),
        .in_item    (back_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .r_x        (r_x),
        .r_y        (r_y),
        .r_z        (r_z),
        .r_w        (r_w),
        .degenerate (degenerate)
    );

endmodule

// ===== bench/qmn_checker.sv =====
// Scoreboard for the quaternion multiply-normalize block: predicts each product and checks it.
`timescale 1ns / 100ps

module qmn_checker #(
    parameter int FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] a_x,
    input  logic signed [15:0] a_y,
    input  logic signed [15:0] a_z,
    input  logic signed [15:0] a_w,
    input  logic signed [15:0] b_x,
    input  logic signed [15:0] b_y,
    input  logic signed [15:0] b_z,
    input  logic signed [15:0] b_w,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] r_x,
    input  logic signed [15:0] r_y,
    input  logic signed [15:0] r_z,
    input  logic signed [15:0] r_w,
    input  logic               degenerate,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
        logic               degen;
    } unit_quat_t;

    unit_quat_t products_due[$];

    // Floor of the square root of a sum of four squares, two bits per step.
    function automatic logic [35:0] root_of(input logic [67:0] s);
        logic [35:0] root;
        logic [71:0] rem;
        logic [71:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 33; i >= 0; i--)
        begin
            rem   = (rem << 2) | 72'(s[2*i +: 2]);
            trial = 72'((root << 2) | 36'd1);
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 36'd1;
            end
            else
            begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic logic signed [15:0] scaled(input longint r, input longint n);
        longint m;
        longint q;
        m = (r < 0 ? -r : r) << FRAC_BITS;
        q = (m + (n >> 1)) / n;
        if (q > (longint'(1) << FRAC_BITS))
            q = longint'(1) << FRAC_BITS;
        if (r < 0)
            q = (-q < -32768) ? -32768 : -q;
        else if (q > 32767)
            q = 32767;
        return 16'(q);
    endfunction

    function automatic unit_quat_t product_of(input logic signed [15:0] ax, ay, az, aw,
                                              input logic signed [15:0] bx, by, bz, bw);
        unit_quat_t  u;
        longint      r[4];
        logic [67:0] sumsq;
        logic [63:0] mag;
        longint      n;
        r[0] = longint'(bw) * ax + longint'(bx) * aw + longint'(by) * az - longint'(bz) * ay;
        r[1] = longint'(bw) * ay + longint'(by) * aw + longint'(bz) * ax - longint'(bx) * az;
        r[2] = longint'(bw) * az + longint'(bz) * aw + longint'(bx) * ay - longint'(by) * ax;
        r[3] = longint'(bw) * aw - longint'(bx) * ax - longint'(by) * ay - longint'(bz) * az;
        sumsq = '0;
        // Squares can pass 2^63, so they are formed from unsigned magnitudes.
        for (int i = 0; i < 4; i++)
        begin
            mag   = 64'(r[i] < 0 ? -r[i] : r[i]);
            sumsq = sumsq + 68'(mag) * 68'(mag);
        end
        if (sumsq == 0)
        begin
            u = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1};
        end
        else
        begin
            n = longint'(root_of(sumsq));
            u = '{scaled(r[0], n), scaled(r[1], n), scaled(r[2], n), scaled(r[3], n), 1'b0};
        end
        return u;
    endfunction

    assign pending = products_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        unit_quat_t e;
        if (!rst_n)
        begin
            errors = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                products_due.push_back(product_of(a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w));
            if (out_valid && out_ready)
            begin
                if (products_due.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    errors++;
                end
                else
                begin
                    e = products_due.pop_front();
                    if (r_x !== e.x)
                    begin
                        $error("r_x expected %0d actual %0d", e.x, r_x);
                        errors++;
                    end
                    if (r_y !== e.y)
                    begin
                        $error("r_y expected %0d actual %0d", e.y, r_y);
                        errors++;
                    end
                    if (r_z !== e.z)
                    begin
                        $error("r_z expected %0d actual %0d", e.z, r_z);
                        errors++;
                    end
                    if (r_w !== e.w)
                    begin
                        $error("r_w expected %0d actual %0d", e.w, r_w);
                        errors++;
                    end
                    if (degenerate !== e.degen)
                    begin
                        $error("degenerate expected %0b actual %0b", e.degen, degenerate);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
// Top of the quaternion multiply-normalize testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] a_x, a_y, a_z, a_w;
    logic signed [15:0] b_x, b_y, b_z, b_w;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] r_x, r_y, r_z, r_w;
    logic               degenerate;
    int                 errors;
    int                 pending;

    // While this is set, neither side inserts gaps, so the pipeline runs back to back.
    logic               no_idle;
    // Number of results taken so far; the receiver uses it to place its long hold-off.
    int                 results_taken;

    localparam int RANDOM_ITEMS = 730;
    localparam int DRAIN_CYCLES = 120;

    quaternion_multiply_normalize uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
        .degenerate(degenerate)
    );

    qmn_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
        .degenerate(degenerate),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Offers one quaternion pair after a random gap (none while no_idle is set) and returns at
    // the falling edge that follows its transfer. Entered at a falling edge, so valid changes only there.
    task automatic offer_pair(input logic signed [15:0] ax, ay, az, aw,
                              input logic signed [15:0] bx, by, bz, bw);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        a_x <= ax; a_y <= ay; a_z <= az; a_w <= aw;
        b_x <= bx; b_y <= by; b_z <= bz; b_w <= bw;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // A component of a random operand. Most values lie in the stated Q1.14 range; some are
    // small so that near-degenerate products occur, and some are any 16-bit pattern.
    function automatic logic signed [15:0] any_comp(input int kind);
        case (kind)
            0:       return 16'($urandom);
            1:       return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Receiver: a random stall before every result, one long hold-off after the first
    // hundred results, and no stalls while the back-to-back phase runs.
    initial
    begin
        int stall;
        results_taken = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (results_taken == 100)
                stall = 300;
            else
                stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            results_taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        int kind;
        logic signed [15:0] q[8];
        no_idle = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w} = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: zero operands give the degenerate flag, identities, the range
        // ends, the most negative pattern, and a pure rotation of each axis.
        offer_pair(0, 0, 0, 0, 0, 0, 0, 16384);
        offer_pair(0, 0, 0, 16384, 0, 0, 0, 0);
        offer_pair(0, 0, 0, 0, 0, 0, 0, 0);
        offer_pair(0, 0, 0, 16384, 0, 0, 0, 16384);
        offer_pair(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384);
        offer_pair(-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384);
        offer_pair(16384, 0, 0, 0, 0, 16384, 0, 0);
        offer_pair(0, 16384, 0, 0, 0, 0, 16384, 0);
        offer_pair(0, 0, 16384, 0, 16384, 0, 0, 0);
        offer_pair(-16384, 0, 0, 0, 0, 0, 0, 16384);
        offer_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        offer_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        offer_pair(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767);
        offer_pair(-32768, 0, 0, 0, 0, 0, 0, -32768);
        offer_pair(1, 0, 0, 0, 0, 0, 0, 1);
        offer_pair(0, 0, 0, -1, 0, 0, 0, 1);
        offer_pair(1, 1, 1, 1, 1, -1, 1, -1);
        offer_pair(16384, -16384, 0, 0, 0, 0, 16384, -16384);
        offer_pair(11585, 0, 0, 11585, 0, 11585, 0, 11585);
        offer_pair(3, 4, 0, 0, 0, 0, 0, 5);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Let the pipeline drain completely once, then run a stretch with no gaps.
            if (i == 300)
            begin
                in_valid <= 1'b0;
                while (pending != 0)
                    @(negedge clk);
            end
            no_idle = (i >= 450 && i < 550);
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 8; k++)
                q[k] = any_comp(kind < 2 ? 0 : (kind < 3 ? 1 : 2));
            // Now and then one operand is all zero, which must raise the degenerate flag.
            if (kind == 9 && $urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1))
                begin
                    for (int k = 0; k < 4; k++)
                        q[k] = '0;
                end
                else
                begin
                    for (int k = 4; k < 8; k++)
                        q[k] = '0;
                end
            end
            offer_pair(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
